/* hw/rtl/rrc_pkg.sv */
// Package for the rational reduce-and-compare block: widths, payload and control types.
`default_nettype none

package rrc_pkg;

    localparam int RRC_WIDTH = 16;
    localparam int RRC_KW    = $clog2(RRC_WIDTH);

    typedef struct packed {
        logic [RRC_WIDTH-1:0] first_numerator;
        logic [RRC_WIDTH-1:0] first_denominator;
        logic [RRC_WIDTH-1:0] second_numerator;
        logic [RRC_WIDTH-1:0] second_denominator;
    } rrc_in_t;

    typedef struct packed {
        logic [RRC_WIDTH-1:0] first_reduced_numerator;
        logic [RRC_WIDTH-1:0] first_reduced_denominator;
        logic [RRC_WIDTH-1:0] second_reduced_numerator;
        logic [RRC_WIDTH-1:0] second_reduced_denominator;
        logic                 fractions_equal;
    } rrc_out_t;

    typedef struct packed {
        logic                 start;
        logic [RRC_WIDTH-1:0] numerator;
        logic [RRC_WIDTH-1:0] denominator;
    } rrc_core_req_t;

    typedef struct packed {
        logic                 done;
        logic [RRC_WIDTH-1:0] numerator;
        logic [RRC_WIDTH-1:0] denominator;
    } rrc_core_rsp_t;

    typedef enum logic [2:0] {
        CORE_IDLE,
        CORE_GCD,
        CORE_DIV_N,
        CORE_DIV_D,
        CORE_DONE
    } rrc_core_state_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SECOND,
        ST_OUT
    } rrc_state_t;

endpackage

`default_nettype wire

/* hw/rtl/rational_reduce_and_compare.sv */
// Top level of the rational reduce-and-compare block: sequencer, payload registers and compare.
//
// Usage: a request transaction on req_valid/req_ready carries two unsigned fractions.
// The block reduces each to lowest terms by dividing both parts by their greatest
// common divisor; a fraction whose smaller part is 0 or 1 passes through unchanged.
// One response transaction on rsp_valid/rsp_ready follows each request, with the
// reduced pairs and a flag that is set when both reduced pairs match exactly.
// Both fractions go through one reduction core in turn, all on one shared subtractor.
// A fraction that passes through skips the reduction; any other goes through binary GCD
// steps, a final compare and 16 restoring division steps for each part. rsp_valid rises
// once both fractions have gone through the core.
// One transaction is in the block at a time: req_ready is high only while it is idle,
// and a result held on the response channel while rsp_ready is low keeps the block
// busy until it is taken. Reset clears the sequencer: req_ready comes up and
// rsp_valid is low.
`default_nettype none

module rational_reduce_and_compare (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire rrc_pkg::rrc_in_t req_data,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output rrc_pkg::rrc_out_t     rsp_data
);
    import rrc_pkg::*;

    rrc_state_t state_reg, state_next;

    rrc_in_t       in_reg, in_next;
    rrc_out_t      out_reg, out_next;
    rrc_core_req_t core_req;
    rrc_core_rsp_t core_rsp;

    rrc_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (core_req),
        .rsp   (core_rsp)
    );

    always_comb
    begin
        state_next           = state_reg;
        in_next              = in_reg;
        out_next             = out_reg;
        core_req.start       = 1'b0;
        core_req.numerator   = req_data.first_numerator;
        core_req.denominator = req_data.first_denominator;
        req_ready            = 1'b0;
        rsp_valid            = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    in_next        = req_data;
                    core_req.start = 1'b1;
                    state_next     = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                core_req.numerator   = in_reg.second_numerator;
                core_req.denominator = in_reg.second_denominator;
                if (core_rsp.done)
                begin
                    out_next.first_reduced_numerator   = core_rsp.numerator;
                    out_next.first_reduced_denominator = core_rsp.denominator;
                    core_req.start = 1'b1;
                    state_next     = ST_SECOND;
                end
            end
            ST_SECOND:
            begin
                core_req.numerator   = in_reg.second_numerator;
                core_req.denominator = in_reg.second_denominator;
                if (core_rsp.done)
                begin
                    out_next.second_reduced_numerator   = core_rsp.numerator;
                    out_next.second_reduced_denominator = core_rsp.denominator;
                    out_next.fractions_equal =
                        (out_reg.first_reduced_numerator == core_rsp.numerator) &&
                        (out_reg.first_reduced_denominator == core_rsp.denominator);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg  <= in_next;
        out_reg <= out_next;
    end

    assign rsp_data = out_reg;

`ifndef ASSERT_OFF
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid))
        else $error("Request and response channels active together");
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        core_rsp.done |-> (state_reg == ST_FIRST || state_reg == ST_SECOND))
        else $error("Core finished while the sequencer was not waiting for it");
    a_equal_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.fractions_equal ==
            ((rsp_data.first_reduced_numerator == rsp_data.second_reduced_numerator) &&
             (rsp_data.first_reduced_denominator == rsp_data.second_reduced_denominator))))
        else $error("Equal flag disagrees with the reduced pairs");
    a_second_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIRST && core_rsp.done) |=> (state_reg == ST_SECOND))
        else $error("Second fraction was not started after the first");
`endif

endmodule

`default_nettype wire

/* hw/rtl/rrc_core.sv */
// Reduction core: binary GCD and restoring division of one fraction on a shared subtractor.
`default_nettype none

module rrc_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rrc_pkg::rrc_core_req_t req,
    output rrc_pkg::rrc_core_rsp_t     rsp
);
    import rrc_pkg::*;

    localparam int W = RRC_WIDTH;

    rrc_core_state_t state_reg, state_next;

    logic [W-1:0]      n_reg, n_next;
    logic [W-1:0]      d_reg, d_next;
    logic [W-1:0]      a_reg, a_next;
    logic [W-1:0]      b_reg, b_next;
    logic [RRC_KW-1:0] k_reg, k_next;
    logic [W-1:0]      g_reg, g_next;
    logic [W-1:0]      rem_reg, rem_next;
    logic [W-1:0]      quo_reg, quo_next;
    logic [RRC_KW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]      rn_reg, rn_next;
    logic [W-1:0]      rd_reg, rd_next;

    logic [W:0]   op_x;
    logic [W:0]   op_y;
    logic [W+1:0] diff;
    logic         borrow;
    logic         diff_zero;
    logic [W-1:0] smaller;
    logic [W-1:0] quo_step;
    logic [W-1:0] rem_step;

    // The one subtractor that serves both the GCD and the division.
    always_comb
    begin
        if (state_reg == CORE_GCD)
        begin
            op_x = {1'b0, a_reg};
            op_y = {1'b0, b_reg};
        end
        else
        begin
            op_x = {rem_reg, quo_reg[W-1]};
            op_y = {1'b0, g_reg};
        end
        diff      = {1'b0, op_x} - {1'b0, op_y};
        borrow    = diff[W+1];
        diff_zero = (diff == '0);
    end

    always_comb
    begin
        smaller  = (req.numerator < req.denominator) ? req.numerator : req.denominator;
        rem_step = borrow ? op_x[W-1:0] : diff[W-1:0];
        quo_step = {quo_reg[W-2:0], ~borrow};
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        g_next     = g_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        rn_next    = rn_reg;
        rd_next    = rd_reg;
        unique case (state_reg)
            CORE_IDLE,
            CORE_DONE:
            begin
                state_next = CORE_IDLE;
                if (req.start)
                begin
                    n_next = req.numerator;
                    d_next = req.denominator;
                    a_next = req.numerator;
                    b_next = req.denominator;
                    k_next = '0;
                    if (smaller <= W'(1))
                    begin
                        rn_next    = req.numerator;
                        rd_next    = req.denominator;
                        state_next = CORE_DONE;
                    end
                    else
                    begin
                        state_next = CORE_GCD;
                    end
                end
            end
            CORE_GCD:
            begin
                if (!a_reg[0] && !b_reg[0])
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + RRC_KW'(1);
                end
                else if (!a_reg[0])
                begin
                    a_next = a_reg >> 1;
                end
                else if (!b_reg[0])
                begin
                    b_next = b_reg >> 1;
                end
                else if (diff_zero)
                begin
                    g_next     = a_reg << k_reg;
                    quo_next   = n_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = CORE_DIV_N;
                end
                else if (borrow)
                begin
                    a_next = b_reg;
                    b_next = a_reg;
                end
                else
                begin
                    a_next = diff[W:1];
                end
            end
            CORE_DIV_N:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg + RRC_KW'(1);
                if (cnt_reg == RRC_KW'(W-1))
                begin
                    rn_next    = quo_step;
                    quo_next   = d_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = CORE_DIV_D;
                end
            end
            CORE_DIV_D:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg + RRC_KW'(1);
                if (cnt_reg == RRC_KW'(W-1))
                begin
                    rd_next    = quo_step;
                    state_next = CORE_DONE;
                end
            end
            default:
            begin
                state_next = CORE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CORE_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        k_reg   <= k_next;
        g_reg   <= g_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        rn_reg  <= rn_next;
        rd_reg  <= rd_next;
    end

    assign rsp.done        = (state_reg == CORE_DONE);
    assign rsp.numerator   = rn_reg;
    assign rsp.denominator = rd_reg;

`ifndef ASSERT_OFF
    a_gcd_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CORE_GCD && $past(state_reg) != CORE_GCD)
        |-> (a_reg >= W'(2) && b_reg >= W'(2)))
        else $error("GCD started on a fraction that should pass through");
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CORE_DIV_N || state_reg == CORE_DIV_D) |-> (g_reg != '0))
        else $error("Division started with a zero divisor");
    a_div_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CORE_DIV_D && cnt_reg == RRC_KW'(W-1)) |=> (state_reg == CORE_DONE))
        else $error("Second division did not finish after its last step");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.done && !req.start) |=> !rsp.done)
        else $error("Core completion lasted more than one cycle");
`endif

endmodule

`default_nettype wire
